/* hw/rtl/cursor_sprite_overlay_top_assert.svh */
// ---------------------------------------------------------------------------
// cursor_sprite_overlay_top_assert : assertion macros for the cursor overlay
// Clocked on clk, switched off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef CURSOR_SPRITE_OVERLAY_TOP_ASSERT_SVH
`define CURSOR_SPRITE_OVERLAY_TOP_ASSERT_SVH

// Same-cycle implication
`define CSO_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cursor overlay check failed");

// Next-cycle implication
`define CSO_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cursor overlay check failed");

`endif

/* hw/rtl/cso_pkg.sv */
// ---------------------------------------------------------------------------
// cso_pkg : cursor overlay types and constants
// Cursor bitmaps, hotspot, register map and shared types.
// ---------------------------------------------------------------------------
package cso_pkg;

  localparam int COORD_W  = 12;
  localparam int SIZE_W   = 13;
  localparam int DIFF_W   = 14;
  localparam int CELL_W   = 4;
  localparam int PIX_W    = 32;

  localparam int CURSOR_SIZE = 16;
  localparam int HOTSPOT_X   = 2;
  localparam int HOTSPOT_Y   = 14;

  localparam logic [PIX_W-1:0] PIX_BLACK = 32'hFF00_0000;
  localparam logic [PIX_W-1:0] PIX_WHITE = 32'hFFFF_FFFF;

  localparam logic [SIZE_W-1:0] WIDTH_RST  = 13'd1920;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 13'd1080;

  // Register map, index = paddr[4:2]
  localparam int PADDR_W = 5;
  localparam logic [2:0] REG_POINTER_X = 3'd0;
  localparam logic [2:0] REG_POINTER_Y = 3'd1;
  localparam logic [2:0] REG_ENABLE    = 3'd2;
  localparam logic [2:0] REG_WIDTH     = 3'd3;
  localparam logic [2:0] REG_HEIGHT    = 3'd4;

  // Row 0 is the top cursor row (lowest pixel row); bit 15 is cursor column 0
  localparam logic [15:0] BODY_ROWS [CURSOR_SIZE] = '{
    16'h0000, 16'h0180, 16'h0180, 16'h0300, 16'h2300, 16'h3600, 16'h3e00, 16'h3fc0,
    16'h3f80, 16'h3f00, 16'h3e00, 16'h3c00, 16'h3800, 16'h3000, 16'h2000, 16'h0000
  };

  localparam logic [15:0] EDGE_ROWS [CURSOR_SIZE] = '{
    16'h01c0, 16'h0240, 16'h0240, 16'h6480, 16'h5480, 16'h4900, 16'h4100, 16'h4020,
    16'h4040, 16'h4080, 16'h4100, 16'h4200, 16'h4400, 16'h4800, 16'h5000, 16'h6000
  };

  typedef enum logic [1:0] {
    HIT_NONE = 2'd0,
    HIT_BODY = 2'd1,
    HIT_EDGE = 2'd2
  } hit_t;

  typedef struct packed {
    logic [COORD_W-1:0] pointer_x;
    logic [COORD_W-1:0] pointer_y;
    logic               enable;
    logic [SIZE_W-1:0]  width;
    logic [SIZE_W-1:0]  height;
  } cso_cfg_t;

endpackage

/* hw/rtl/cso_hit.sv */
// ---------------------------------------------------------------------------
// cso_hit : cursor cell lookup
// Classifies one pixel position as body, outline or pass-through.
// ---------------------------------------------------------------------------
module cso_hit import cso_pkg::*; (
  input  cso_cfg_t           cfg,
  input  logic [COORD_W-1:0] col,
  input  logic [COORD_W-1:0] row,
  output hit_t               hit
);

  logic [DIFF_W-1:0] dx;
  logic [DIFF_W-1:0] dy;
  logic              in_image;
  logic              in_cell;
  logic [CELL_W-1:0] cc;
  logic [CELL_W-1:0] cr;
  logic [CELL_W-1:0] bit_idx;
  logic              body_bit;
  logic              edge_bit;

  // Cell offset, two's complement; inside the cell iff upper bits all zero
  assign dx = {2'b00, col} + DIFF_W'(HOTSPOT_X) - {2'b00, cfg.pointer_x};
  assign dy = {2'b00, row} + DIFF_W'(HOTSPOT_Y) - {2'b00, cfg.pointer_y};

  assign in_cell  = (dx[DIFF_W-1:CELL_W] == '0) && (dy[DIFF_W-1:CELL_W] == '0);
  assign in_image = ({1'b0, col} < cfg.width) && ({1'b0, row} < cfg.height);

  assign cc      = dx[CELL_W-1:0];
  assign cr      = dy[CELL_W-1:0];
  assign bit_idx = CELL_W'(CURSOR_SIZE - 1) - cc;

  assign body_bit = BODY_ROWS[cr][bit_idx];
  assign edge_bit = EDGE_ROWS[cr][bit_idx];

  always_comb begin
    hit = HIT_NONE;
    if (cfg.enable && in_image && in_cell) begin
      if (body_bit) begin
        hit = HIT_BODY;
      end else if (edge_bit) begin
        hit = HIT_EDGE;
      end
    end
  end

endmodule

/* hw/rtl/cursor_sprite_overlay_top.sv */
// ---------------------------------------------------------------------------
// cursor_sprite_overlay_top : 16x16 hardware cursor over a BGRA pixel stream
// Path: an accepted word goes to the input register (s1), then to the result register on out_.
// Throughput: one word per cycle while out_ready is high, set by the input and result register pair.
// Reset: sync active-low; clears valids and loads register reset values.
// ---------------------------------------------------------------------------
`include "cursor_sprite_overlay_top_assert.svh"

module cursor_sprite_overlay_top import cso_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,

  // Pixel input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [COORD_W-1:0] in_pixel_col,
  input  logic [COORD_W-1:0] in_pixel_row,
  input  logic [PIX_W-1:0]   in_pixel_in,

  // Result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [PIX_W-1:0]   out_pixel_out,
  output logic [1:0]         out_cursor_hit,

  // APB-style register port
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  // -------------------------------------------------------------------------
  // Registers. Writes land on the access phase; pready is tied high so
  // there are never wait states. Unmapped indexes are dropped on write and
  // read as zero.
  // -------------------------------------------------------------------------
  cso_cfg_t   cfg_r;
  cso_cfg_t   cfg_nxt;
  logic       cfg_wr;
  logic [2:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[PADDR_W-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (reg_idx)
        REG_POINTER_X: cfg_nxt.pointer_x = cfg_pwdata[COORD_W-1:0];
        REG_POINTER_Y: cfg_nxt.pointer_y = cfg_pwdata[COORD_W-1:0];
        REG_ENABLE:    cfg_nxt.enable    = cfg_pwdata[0];
        REG_WIDTH:     cfg_nxt.width     = cfg_pwdata[SIZE_W-1:0];
        REG_HEIGHT:    cfg_nxt.height    = cfg_pwdata[SIZE_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_POINTER_X: cfg_prdata = 32'(cfg_r.pointer_x);
      REG_POINTER_Y: cfg_prdata = 32'(cfg_r.pointer_y);
      REG_ENABLE:    cfg_prdata = 32'(cfg_r.enable);
      REG_WIDTH:     cfg_prdata = 32'(cfg_r.width);
      REG_HEIGHT:    cfg_prdata = 32'(cfg_r.height);
      default:       cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pointer_x <= '0;
      cfg_r.pointer_y <= '0;
      cfg_r.enable    <= 1'b0;
      cfg_r.width     <= WIDTH_RST;
      cfg_r.height    <= HEIGHT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // -------------------------------------------------------------------------
  // Two-register pipe: input stage (s1) then result stage. Both move on
  // together whenever the result register is empty or being drained, so
  // a full pipe keeps streaming one word per cycle under out_ready.
  // -------------------------------------------------------------------------
  logic               s1_valid_r;
  logic [COORD_W-1:0] s1_col_r;
  logic [COORD_W-1:0] s1_row_r;
  logic [PIX_W-1:0]   s1_pix_r;

  logic               out_valid_r;
  logic [PIX_W-1:0]   out_pixel_out_r;
  hit_t               out_cursor_hit_r;

  logic               advance;
  logic               in_acc;
  hit_t               hit;
  logic [PIX_W-1:0]   pix_nxt;

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;
  assign in_acc   = in_valid && in_ready;

  // Cell lookup on the registered pixel position
  cso_hit u_hit (
    .cfg (cfg_r),
    .col (s1_col_r),
    .row (s1_row_r),
    .hit (hit)
  );

  // Body wins over outline inside the lookup; here only the colour select
  always_comb begin
    case (hit)
      HIT_BODY: pix_nxt = PIX_BLACK;
      HIT_EDGE: pix_nxt = PIX_WHITE;
      default:  pix_nxt = s1_pix_r;
    endcase
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_col_r <= in_pixel_col;
      s1_row_r <= in_pixel_row;
      s1_pix_r <= in_pixel_in;
    end
    if (advance && s1_valid_r) begin
      out_pixel_out_r  <= pix_nxt;
      out_cursor_hit_r <= hit;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_out  = out_pixel_out_r;
  assign out_cursor_hit = out_cursor_hit_r;

  // -------------------------------------------------------------------------
  // Checks
  // -------------------------------------------------------------------------
  `CSO_ASSERT_NOW(a_body_black, out_valid_r && (out_cursor_hit_r == HIT_BODY),
                  out_pixel_out_r == PIX_BLACK)
  `CSO_ASSERT_NOW(a_edge_white, out_valid_r && (out_cursor_hit_r == HIT_EDGE),
                  out_pixel_out_r == PIX_WHITE)
  `CSO_ASSERT_NOW(a_full_stall, s1_valid_r && out_valid_r && !out_ready, !in_ready)
  `CSO_ASSERT_NEXT(a_fill_result, s1_valid_r && !out_valid_r, out_valid_r)

endmodule
